### rtl/esc_pkg.sv
package esc_pkg;

  // Number of floors in the shaft and the widths that follow from it.
  localparam int NUM_FLOORS = 16;
  localparam int FLOOR_W    = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
  localparam int COUNT_W    = $clog2(NUM_FLOORS + 1);

  // Fixed field widths of the words on the ports.
  localparam int ACTION_W  = 2;
  localparam int TARGET_W  = 4;
  localparam int MODE_W    = 3;
  localparam int CABIN_W   = 4;
  localparam int PENDING_W = 5;
  localparam int OUTCOME_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [ACTION_W-1:0] {
    ACT_REQUEST = 2'd0,
    ACT_STEP    = 2'd1,
    ACT_CLOSE   = 2'd2,
    ACT_SERVICE = 2'd3
  } action_e;

  typedef enum logic [OUTCOME_W-1:0] {
    OUT_OK          = 2'd0,
    OUT_NOT_ALLOWED = 2'd1,
    OUT_RANGE       = 2'd2,
    OUT_ALREADY     = 2'd3
  } outcome_e;

  // Controller state, one-hot.
  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_UP    = 5'b00010,
    MODE_DOWN  = 5'b00100,
    MODE_DOORS = 5'b01000,
    MODE_MAINT = 5'b10000
  } mode_e;

  // Mode codes as they appear on the result word.
  localparam logic [MODE_W-1:0] MODE_CODE_IDLE  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_UP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_DOWN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_DOORS = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CODE_MAINT = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START   = 2'd2;

  function automatic logic [MODE_W-1:0] mode_code(input mode_e m);
    logic [MODE_W-1:0] c;
    case (m)
      MODE_IDLE:  c = MODE_CODE_IDLE;
      MODE_UP:    c = MODE_CODE_UP;
      MODE_DOWN:  c = MODE_CODE_DOWN;
      MODE_DOORS: c = MODE_CODE_DOORS;
      MODE_MAINT: c = MODE_CODE_MAINT;
      default:    c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

### rtl/esc_if.sv
// Action channel into the controller.
interface esc_in_if
  import esc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [TARGET_W-1:0] target_floor;
  logic                service_on;

  modport source(output valid, action, target_floor, service_on, input ready);
  modport sink(input valid, action, target_floor, service_on, output ready);
endinterface

// Status channel out of the controller.
interface esc_out_if
  import esc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [MODE_W-1:0]    mode;
  logic [CABIN_W-1:0]   cabin_floor;
  logic [PENDING_W-1:0] pending_stops;
  logic [OUTCOME_W-1:0] outcome;

  modport source(output valid, mode, cabin_floor, pending_stops, outcome, input ready);
  modport sink(input valid, mode, cabin_floor, pending_stops, outcome, output ready);
endinterface

### rtl/elevator_stop_controller.sv
// Channel      Direction  Contents
// act_word     in         action, target_floor, service_on
// stat_word    out        mode, cabin_floor, pending_stops, outcome
// cfg_*        in         write enable, register index, 4-bit data
//
// Every accepted action word produces exactly one status word, in the next cycle.
// The controller state is updated at the edge that accepts the action, and the
// status goes to a single output register, so a new action is taken every
// cycle while the output register is empty or is being drained.
// rst_ni clears the mode to idle, the cabin to floor 0, the stops and the
// output valid flag, and sets the floor limits to 0 and 15. A stalled status
// word only holds off new actions; nothing is lost.
module elevator_stop_controller
  import esc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  esc_in_if.sink                act_word,
  esc_out_if.source             stat_word,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Controller state.
  mode_e                   mode_q, mode_d;
  logic [FLOOR_W-1:0]      floor_q, floor_d;
  logic [NUM_FLOORS-1:0]   stops_q, stops_d;
  logic [CFG_DATA_W-1:0]   lowest_q, highest_q;

  // Output register.
  logic                    out_valid_q;
  logic [MODE_W-1:0]       out_mode_q;
  logic [CABIN_W-1:0]      out_cabin_q;
  logic [PENDING_W-1:0]    out_pending_q;
  logic [OUTCOME_W-1:0]    out_outcome_q;

  logic                    act_acc;
  outcome_e                outcome;
  action_e                 action;

  logic [NUM_FLOORS-1:0]   target_bit;
  logic                    target_in_range;
  logic                    target_here;
  logic [NUM_FLOORS-1:0]   stops_req;
  logic [FLOOR_W-1:0]      floor_step;
  logic [NUM_FLOORS-1:0]   step_bit;
  logic [FLOOR_W-1:0]      start_floor;

  // Direction choice from a stop map and a cabin floor: idle with no stops,
  // up when any stop lies above the cabin, down otherwise (this includes a
  // lone stop at the cabin floor).
  function automatic mode_e pick_dir(input logic [NUM_FLOORS-1:0] stops,
                                     input logic [FLOOR_W-1:0]    fl);
    logic [NUM_FLOORS-1:0] above;
    for (int i = 0; i < NUM_FLOORS; i++) begin
      above[i] = (i > int'(fl));
    end
    if (stops == '0) begin
      return MODE_IDLE;
    end else if ((stops & above) != '0) begin
      return MODE_UP;
    end
    return MODE_DOWN;
  endfunction

  assign act_acc        = act_word.valid && act_word.ready;
  assign act_word.ready = !out_valid_q || stat_word.ready;
  assign action         = action_e'(act_word.action);

  // Request decode. Out of range also covers an empty window (lowest above
  // highest) and targets past the top of the shaft.
  always_comb begin
    for (int i = 0; i < NUM_FLOORS; i++) begin
      target_bit[i] = (int'(act_word.target_floor) == i);
    end
  end

  assign target_in_range = (act_word.target_floor >= lowest_q) &&
                           (act_word.target_floor <= highest_q) &&
                           (int'(act_word.target_floor) < NUM_FLOORS);
  assign target_here     = (int'(act_word.target_floor) == int'(floor_q));
  assign stops_req       = (target_in_range && !target_here) ? (stops_q | target_bit)
                                                             : stops_q;

  // One floor of travel, clamped at both ends of the shaft.
  always_comb begin
    floor_step = floor_q;
    if (mode_q == MODE_UP) begin
      if (int'(floor_q) + 1 < NUM_FLOORS) begin
        floor_step = floor_q + FLOOR_W'(1);
      end
    end else if (floor_q != '0) begin
      floor_step = floor_q - FLOOR_W'(1);
    end
    for (int i = 0; i < NUM_FLOORS; i++) begin
      step_bit[i] = (int'(floor_step) == i);
    end
  end

  // Next state and outcome for the offered action.
  always_comb begin
    mode_d  = mode_q;
    floor_d = floor_q;
    stops_d = stops_q;
    outcome = OUT_NOT_ALLOWED;
    case (action)
      ACT_REQUEST: begin
        if (mode_q == MODE_IDLE || mode_q == MODE_UP || mode_q == MODE_DOWN ||
            mode_q == MODE_DOORS) begin
          stops_d = stops_req;
          if (!target_in_range) begin
            outcome = OUT_RANGE;
          end else if (target_here) begin
            outcome = OUT_ALREADY;
          end else begin
            outcome = OUT_OK;
          end
          if (mode_q == MODE_IDLE) begin
            mode_d = pick_dir(stops_req, floor_q);
          end
        end
      end
      ACT_STEP: begin
        if (mode_q == MODE_UP || mode_q == MODE_DOWN) begin
          floor_d = floor_step;
          outcome = OUT_OK;
          if ((stops_q & step_bit) != '0) begin
            stops_d = stops_q & ~step_bit;
            mode_d  = MODE_DOORS;
          end else begin
            mode_d  = pick_dir(stops_q, floor_step);
          end
        end
      end
      ACT_CLOSE: begin
        if (mode_q == MODE_DOORS) begin
          mode_d  = pick_dir(stops_q, floor_q);
          outcome = OUT_OK;
        end
      end
      ACT_SERVICE: begin
        if (mode_q == MODE_IDLE || mode_q == MODE_MAINT) begin
          outcome = OUT_OK;
          mode_d  = act_word.service_on ? MODE_MAINT : MODE_IDLE;
          // Leaving maintenance drops every queued stop.
          if (mode_q == MODE_MAINT && !act_word.service_on) begin
            stops_d = '0;
          end
        end
      end
      default: begin
        outcome = OUT_NOT_ALLOWED;
      end
    endcase
  end

  // Start floor saturates at the top of the shaft.
  assign start_floor = (int'(cfg_data_i) >= NUM_FLOORS) ? FLOOR_W'(NUM_FLOORS - 1)
                                                        : FLOOR_W'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      floor_q   <= '0;
      stops_q   <= '0;
      lowest_q  <= CFG_DATA_W'(0);
      highest_q <= CFG_DATA_W'(15);
    end else begin
      if (act_acc) begin
        mode_q  <= mode_d;
        stops_q <= stops_d;
      end
      // The user must write configuration only while no action is in flight, so
      // that a start floor write never meets a step; the block does not enforce it.
      if (cfg_we_i && cfg_idx_i == CFG_START) begin
        floor_q <= start_floor;
      end else if (act_acc) begin
        floor_q <= floor_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_LOWEST:  lowest_q  <= cfg_data_i;
          CFG_HIGHEST: highest_q <= cfg_data_i;
          default:     ;
        endcase
      end
    end
  end

  // Output register: loads on every accepted action, drains when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (act_acc) begin
      out_valid_q <= 1'b1;
    end else if (stat_word.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (act_acc) begin
      out_mode_q    <= mode_code(mode_d);
      out_cabin_q   <= CABIN_W'(floor_d);
      out_pending_q <= PENDING_W'(COUNT_W'($countones(stops_d)));
      out_outcome_q <= outcome;
    end
  end

  assign stat_word.valid         = out_valid_q;
  assign stat_word.mode          = out_mode_q;
  assign stat_word.cabin_floor   = out_cabin_q;
  assign stat_word.pending_stops = out_pending_q;
  assign stat_word.outcome       = out_outcome_q;

  // Idle is only ever entered with an empty stop map.
  a_idle_no_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_IDLE) |-> (stops_q == '0))
    else $error("idle with pending stops");

  // Every accepted action yields a status word in the next cycle.
  a_status_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    act_acc |=> out_valid_q)
    else $error("status word missing after accepted action");

  // A status word that is taken with no new action behind it is not repeated.
  a_no_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stat_word.ready && !act_acc) |=> !out_valid_q)
    else $error("status word repeated");

  // In maintenance the stop map either holds or is cleared.
  a_maint_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (act_acc && mode_q == MODE_MAINT) |=> (stops_q == $past(stops_q) || stops_q == '0))
    else $error("stop map changed in maintenance");

endmodule

### test/esc_status_pkg.sv
`timescale 1ns / 100ps

package esc_status_pkg;
  import esc_pkg::*;

  // One status word as the controller should report it.
  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [CABIN_W-1:0]   cabin;
    logic [PENDING_W-1:0] pending;
    logic [OUTCOME_W-1:0] outcome;
  } status_t;

  // Tracks the cabin, its mode and the stop map, works out the status word of
  // every accepted action word and compares the words that come back.
  class elevator_status_board;
    logic [CFG_DATA_W-1:0] low_limit;
    logic [CFG_DATA_W-1:0] high_limit;
    logic [MODE_W-1:0]     mode;
    logic [FLOOR_W-1:0]    cabin;
    logic [NUM_FLOORS-1:0] stops;
    status_t               expected_status[$];
    int                    errors;

    function new();
      low_limit  = '0;
      high_limit = '1;
      mode       = MODE_CODE_IDLE;
      cabin      = '0;
      stops      = '0;
      errors     = 0;
    endfunction

    function int outstanding();
      return expected_status.size();
    endfunction

    function void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LOWEST:  low_limit = val;
        CFG_HIGHEST: high_limit = val;
        CFG_START:   cabin = (int'(val) >= NUM_FLOORS) ? FLOOR_W'(NUM_FLOORS - 1) : val;
        default: ;
      endcase
    endfunction

    // Travel direction from the remaining stops; a lone stop at the cabin
    // floor itself counts as below.
    function logic [MODE_W-1:0] next_direction();
      if (stops == '0) return MODE_CODE_IDLE;
      return ((stops >> (int'(cabin) + 1)) != '0) ? MODE_CODE_UP : MODE_CODE_DOWN;
    endfunction

    function logic [OUTCOME_W-1:0] queue_request(input logic [TARGET_W-1:0] target);
      if (target < low_limit || target > high_limit || int'(target) >= NUM_FLOORS)
        return OUT_RANGE;
      if (target == cabin) return OUT_ALREADY;
      stops[target] = 1'b1;
      return OUT_OK;
    endfunction

    // One floor of travel; the ends of the shaft hold the cabin in place but
    // the arrival test still runs.
    function void move_one(input bit upward);
      if (upward) begin
        if (int'(cabin) + 1 < NUM_FLOORS) cabin = cabin + 1'b1;
      end else if (cabin != '0) begin
        cabin = cabin - 1'b1;
      end
      if (stops[cabin]) begin
        stops[cabin] = 1'b0;
        mode = MODE_CODE_DOORS;
      end else begin
        mode = next_direction();
      end
    endfunction

    function void note_action(input logic [ACTION_W-1:0] act,
                              input logic [TARGET_W-1:0] target,
                              input logic svc_on);
      logic [OUTCOME_W-1:0] outcome;
      status_t s;
      outcome = OUT_NOT_ALLOWED;
      case (act)
        ACT_REQUEST: begin
          if (mode == MODE_CODE_IDLE) begin
            outcome = queue_request(target);
            mode = next_direction();
          end else if (mode == MODE_CODE_UP || mode == MODE_CODE_DOWN ||
                       mode == MODE_CODE_DOORS) begin
            outcome = queue_request(target);
          end
        end
        ACT_STEP: begin
          if (mode == MODE_CODE_UP || mode == MODE_CODE_DOWN) begin
            move_one(mode == MODE_CODE_UP);
            outcome = OUT_OK;
          end
        end
        ACT_CLOSE: begin
          if (mode == MODE_CODE_DOORS) begin
            mode = next_direction();
            outcome = OUT_OK;
          end
        end
        default: begin
          if (mode == MODE_CODE_IDLE || mode == MODE_CODE_MAINT) begin
            if (mode == MODE_CODE_MAINT && !svc_on) stops = '0;
            mode = svc_on ? MODE_CODE_MAINT : MODE_CODE_IDLE;
            outcome = OUT_OK;
          end
        end
      endcase
      s.mode    = mode;
      s.cabin   = CABIN_W'(cabin);
      s.pending = PENDING_W'($countones(stops));
      s.outcome = outcome;
      expected_status.push_back(s);
    endfunction

    function void check_status(input status_t got);
      status_t want;
      if (expected_status.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected status word: mode %0d floor %0d stops %0d outcome %0d",
                   got.mode, got.cabin, got.pending, got.outcome);
        return;
      end
      want = expected_status.pop_front();
      if (got.mode !== want.mode || got.cabin !== want.cabin ||
          got.pending !== want.pending || got.outcome !== want.outcome) begin
        errors++;
        if (errors <= 10)
          $display("status word wrong: expected mode %0d floor %0d stops %0d outcome %0d, got mode %0d floor %0d stops %0d outcome %0d",
                   want.mode, want.cabin, want.pending, want.outcome,
                   got.mode, got.cabin, got.pending, got.outcome);
      end
    endfunction
  endclass

endpackage

### test/tb_top.sv
`timescale 1ns / 100ps

// Testbench of the elevator stop controller. Action words go in through the
// action channel, status words come back through the status channel, and a
// scoreboard that models the controller predicts every status word and
// compares it field by field. The floor limits and the start floor are
// programmed between phases, while no word is in flight.
module tb_top;
  import esc_pkg::*;
  import esc_status_pkg::*;

  // The run ends with a failure if it has not finished within this many cycles.
  localparam int CYCLE_LIMIT = 200_000;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Percentages of cycles in which the sender holds back a word and the
  // receiver refuses one.
  int gap_pct;
  int stall_pct;
  int cycle_count = 0;

  elevator_status_board board;

  esc_in_if  act_if ();
  esc_out_if stat_if ();

  elevator_stop_controller i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .act_word   (act_if),
    .stat_word  (stat_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // 8 ns clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake must not keep the run alive forever.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("elevator_stop_controller: mismatch");
      $finish;
    end
  end

  // Receiver side. Every status word accepted at this edge is checked against
  // the oldest prediction, and ready is redrawn for the next cycle.
  always @(posedge clk) begin
    status_t got;
    got.mode    = stat_if.mode;
    got.cabin   = stat_if.cabin_floor;
    got.pending = stat_if.pending_stops;
    got.outcome = stat_if.outcome;
    if (rst_n === 1'b1 && stat_if.valid === 1'b1 && stat_if.ready === 1'b1)
      board.check_status(got);
    stat_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Presents one action word and returns at the edge that accepts it. Before
  // the word, the sender may sit idle for a random number of cycles. Valid is
  // left high after acceptance so that back-to-back words need no extra
  // assignment in the same step.
  task automatic send_action(input logic [ACTION_W-1:0] act,
                             input logic [TARGET_W-1:0] target,
                             input logic svc_on);
    while ($urandom_range(0, 99) < gap_pct) begin
      act_if.valid <= 1'b0;
      @(posedge clk);
    end
    act_if.valid        <= 1'b1;
    act_if.action       <= act;
    act_if.target_floor <= target;
    act_if.service_on   <= svc_on;
    @(posedge clk);
    while (act_if.ready !== 1'b1) @(posedge clk);
    board.note_action(act, target, svc_on);
  endtask

  // Programs the registers once every status word has come back. Write enable
  // stays high over consecutive writes and is dropped once at the end. With
  // start_only set, only the start floor is written.
  task automatic program_floors(input logic [CFG_DATA_W-1:0] low,
                                input logic [CFG_DATA_W-1:0] high,
                                input logic [CFG_DATA_W-1:0] start,
                                input bit start_only);
    act_if.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    if (!start_only) begin
      cfg_idx  <= CFG_LOWEST;
      cfg_data <= low;
      @(posedge clk);
      board.apply_register(CFG_LOWEST, low);
      cfg_idx  <= CFG_HIGHEST;
      cfg_data <= high;
      @(posedge clk);
      board.apply_register(CFG_HIGHEST, high);
    end
    cfg_idx  <= CFG_START;
    cfg_data <= start;
    @(posedge clk);
    board.apply_register(CFG_START, start);
    cfg_we <= 1'b0;
  endtask

  // Picks an action that the present mode accepts most of the time, so the
  // cabin actually travels, serves stops and cycles through maintenance.
  // About one word in seven is a fully random action, legal or not.
  task automatic send_random_item();
    logic [ACTION_W-1:0] act;
    logic [TARGET_W-1:0] target;
    logic                svc_on;
    int                  pick;
    target = TARGET_W'($urandom_range(0, 15));
    svc_on = 1'($urandom_range(0, 1));
    act    = ACTION_W'($urandom_range(0, 3));
    pick   = $urandom_range(0, 99);
    if (pick >= 15) begin
      case (board.mode)
        MODE_CODE_IDLE:                 act = (pick < 80) ? ACT_REQUEST : ACT_SERVICE;
        MODE_CODE_UP, MODE_CODE_DOWN:   act = (pick < 70) ? ACT_STEP : ACT_REQUEST;
        MODE_CODE_DOORS:                act = (pick < 60) ? ACT_CLOSE : ACT_REQUEST;
        default: begin
          if (pick < 80) act = ACT_SERVICE;
        end
      endcase
    end
    send_action(act, target, svc_on);
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] low,
                           input logic [CFG_DATA_W-1:0] high,
                           input logic [CFG_DATA_W-1:0] start,
                           input int gap, input int stall, input int count);
    program_floors(low, high, start, 1'b0);
    gap_pct   = gap;
    stall_pct = stall;
    repeat (count) send_random_item();
  endtask

  initial begin
    rst_n               = 1'b0;
    act_if.valid        = 1'b0;
    act_if.action       = ACT_REQUEST;
    act_if.target_floor = '0;
    act_if.service_on   = 1'b0;
    stat_if.ready       = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = CFG_LOWEST;
    cfg_data            = '0;
    gap_pct             = 0;
    stall_pct           = 0;
    board               = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Requests may name floors 1 to 14 only, so both ends of
    // the target field fall out of range.
    program_floors(4'd1, 4'd14, 4'd0, 1'b0);
    send_action(ACT_STEP, 4'd0, 1'b0);       // Step while idle is refused.
    send_action(ACT_CLOSE, 4'd0, 1'b0);      // So is closing doors.
    send_action(ACT_REQUEST, 4'd0, 1'b0);    // Below the lowest floor.
    send_action(ACT_REQUEST, 4'd15, 1'b0);   // Above the highest floor.
    send_action(ACT_SERVICE, 4'd0, 1'b0);    // Service off in idle stays idle.
    send_action(ACT_SERVICE, 4'd0, 1'b1);    // Enter maintenance.
    send_action(ACT_REQUEST, 4'd5, 1'b0);    // Requests are refused there.
    send_action(ACT_SERVICE, 4'd9, 1'b1);    // Staying in maintenance.
    send_action(ACT_SERVICE, 4'd0, 1'b0);    // Back to idle.
    send_action(ACT_REQUEST, 4'd14, 1'b0);   // Starts the cabin upward.
    send_action(ACT_REQUEST, 4'd3, 1'b1);    // Queued on the way.
    repeat (3) send_action(ACT_STEP, 4'd0, 1'b0);
    send_action(ACT_REQUEST, 4'd3, 1'b0);    // Already at that floor.
    send_action(ACT_CLOSE, 4'd0, 1'b0);
    // Put the moving cabin at the top of the shaft: the step there holds it
    // in place and turns it around.
    program_floors(4'd0, 4'd0, 4'd15, 1'b1);
    send_action(ACT_STEP, 4'd0, 1'b0);
    send_action(ACT_STEP, 4'd0, 1'b0);
    send_action(ACT_REQUEST, 4'd1, 1'b0);
    send_action(ACT_CLOSE, 4'd0, 1'b0);
    // Same at the bottom while heading down.
    program_floors(4'd0, 4'd0, 4'd0, 1'b1);
    send_action(ACT_STEP, 4'd0, 1'b0);
    send_action(ACT_STEP, 4'd0, 1'b0);
    // The only stop left is the floor the doors are open at; closing must
    // head down.
    send_action(ACT_REQUEST, 4'd6, 1'b0);
    program_floors(4'd0, 4'd0, 4'd6, 1'b1);
    send_action(ACT_CLOSE, 4'd0, 1'b0);
    send_action(ACT_STEP, 4'd0, 1'b0);
    send_action(ACT_STEP, 4'd0, 1'b0);
    send_action(ACT_CLOSE, 4'd0, 1'b0);

    // Random part: several floor windows, an empty one where the lowest floor
    // is above the highest among them, and every idling pattern.
    run_phase(4'd0,  4'd15, 4'd7,  0,  0,  300);
    run_phase(4'd3,  4'd12, 4'd15, 62, 0,  300);
    run_phase(4'd10, 4'd5,  4'd0,  0,  62, 150);
    run_phase(4'd15, 4'd15, 4'd8,  25, 25, 150);
    run_phase(4'd0,  4'd0,  4'd10, 0,  0,  100);
    run_phase(4'd0,  4'd15, 4'd0,  25, 25, 450);

    act_if.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("elevator_stop_controller: match");
    end else begin
      $display("elevator_stop_controller: mismatch");
    end
    $finish;
  end

endmodule
